// File: src/string_delimiter_splitter_defines.svh
// assertion macros shared by the string delimiter splitter rtl
`ifndef STRING_DELIMITER_SPLITTER_DEFINES_SVH
`define STRING_DELIMITER_SPLITTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SDS_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SDS_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: src/sds_pkg.sv
// shared types and constants of the string delimiter splitter
`timescale 1ns / 1ps
package sds_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_HIGH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKEN    = 2'd3;

  localparam logic [4:0]  DELIM_LENGTH_RESET = 5'd1;
  localparam logic [63:0] DELIM_LOW_RESET    = 64'd44;
  localparam logic [63:0] DELIM_HIGH_RESET   = 64'd0;
  localparam logic [15:0] TOKEN_LIMIT_RESET  = 16'd32765;
  localparam logic [15:0] TOKEN_LEN_SAT      = 16'hFFFF;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic take_in;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    byte_t token_byte;
    logic  close_token;
    logic  token_overflow;
    logic  last_of_run;
  } result_t;

endpackage

// File: src/string_delimiter_splitter.sv
// top level of the multi-byte delimiter string splitter
//
//   channel | ports          | contents
//   --------+----------------+-----------------------------------------------
//   input   | in_t*          | one string byte per transfer, tlast ends string
//   result  | out_t*         | token byte or token close, tlast ends the run
//   config  | cfg_*          | register index and 64-bit write data
//
// an item occupies the block until its run of results is done, one result per
// cycle while the result buffer has room, set by the single result push of the
// cell-chain sequencer
// rst_n is synchronous and active low; it restores the register defaults and
// empties the window, the token counters and the result buffer
// a stall on out_tready fills the two-entry result buffer, after which the
// sequencer holds and in_tready stays low
`include "string_delimiter_splitter_defines.svh"
`timescale 1ns / 1ps
module string_delimiter_splitter #(
  parameter int DELIM_MAX = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // string_end
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] token_byte
  output logic [1:0]  out_tuser,  // [0] close_token, [1] token_overflow
  output logic        out_tlast,  // last_of_run
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [sds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sds_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sds_pkg::*;

  // window count holds 0..DELIM_MAX
  localparam int CW = $clog2(DELIM_MAX + 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  // configuration registers
  logic [4:0]  delim_len_r;
  logic [63:0] delim_lo_r;
  logic [63:0] delim_hi_r;
  logic [15:0] max_tok_r;

  // string state
  logic [1:0]    state_r,    state_nxt;
  logic [CW-1:0] count_r,    count_nxt;
  logic          end_pend_r, end_pend_nxt;
  logic          ended_r,    ended_nxt;
  logic [15:0]   tl_r,       tl_nxt;
  logic          ovf_r,      ovf_nxt;

  // step decode
  logic [1:0]    mode;
  logic [1:0]    next_mode;
  logic [CW-1:0] c;
  logic [CW-1:0] c_m1;
  logic [CW-1:0] len;
  logic          endp;
  logic          take;
  logic          ended_e;
  logic          in_fire;
  logic          space;
  logic          pre0;
  logic          pre1;
  logic          emit_byte;
  logic          emit_close;
  logic          done;
  logic          clear_str;
  logic          shift;
  logic [15:0]   tl_inc;
  logic          push;
  result_t       res;
  result_t       out_res;

  // cell chain signals
  byte_t              dbyte [DELIM_MAX];
  byte_t              eff   [DELIM_MAX];
  logic [DELIM_MAX-1:0] eq0;
  logic [DELIM_MAX-1:0] eq1;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE) && space;
  assign in_fire   = in_tvalid && in_tready;

  // effective delimiter length: zero reads as one, clamp to the window depth
  always_comb begin
    if (delim_len_r == 5'd0) begin
      len = CW'(1);
    end else if (int'(delim_len_r) > DELIM_MAX) begin
      len = CW'(DELIM_MAX);
    end else begin
      len = CW'(delim_len_r);
    end
  end

  // the window being worked on: on a cycle that accepts a present byte, that byte is
  // appended at the count position, otherwise the stored window is reused
  always_comb begin
    mode    = ST_IDLE;
    c       = count_r;
    endp    = end_pend_r;
    take    = 1'b0;
    ended_e = ended_r;
    if (state_r == ST_IDLE) begin
      if (in_fire && in_tuser) begin
        mode    = ST_SCAN;
        c       = count_r + CW'(1);
        endp    = in_tlast;
        take    = 1'b1;
        ended_e = 1'b0;
      end else if (in_fire && in_tlast) begin
        mode = ST_FLUSH;
        endp = 1'b1;
      end
    end else begin
      mode = state_r;
    end
  end

  assign c_m1 = c - CW'(1);

  // delimiter bytes per cell, beyond the sixteenth they read as zero
  for (genvar i = 0; i < DELIM_MAX; i++) begin : g_cell
    sds_pkg::cell_ctl_t ctl;
    byte_t              next_eff;
    byte_t              d_prev;

    if (i < 8) begin : g_lo
      assign dbyte[i] = delim_lo_r[8*i +: 8];
    end else if (i < 16) begin : g_hi
      assign dbyte[i] = delim_hi_r[8*(i-8) +: 8];
    end else begin : g_zero
      assign dbyte[i] = 8'h00;
    end

    if (i == DELIM_MAX - 1) begin : g_tail
      assign next_eff = 8'h00;
    end else begin : g_link
      assign next_eff = eff[i+1];
    end

    if (i == 0) begin : g_head
      assign d_prev = 8'h00;
    end else begin : g_body
      assign d_prev = dbyte[i-1];
    end

    assign ctl.take_in = take && (count_r == CW'(i));
    assign ctl.shift   = shift;

    sds_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .in_byte  (in_tdata),
      .next_eff (next_eff),
      .d_here   (dbyte[i]),
      .d_prev   (d_prev),
      .eff      (eff[i]),
      .eq0      (eq0[i]),
      .eq1      (eq1[i])
    );
  end

  // pre0: the window is a prefix of the delimiter
  // pre1: the window minus its front byte is a prefix of the delimiter
  always_comb begin
    pre0 = (c <= len);
    pre1 = (c_m1 <= len);
    for (int i = 0; i < DELIM_MAX; i++) begin
      if (CW'(i) < c) begin
        if (!eq0[i]) begin
          pre0 = 1'b0;
        end
        if ((i != 0) && !eq1[i]) begin
          pre1 = 1'b0;
        end
      end
    end
  end

  // saturating token length after one more byte
  assign tl_inc = (tl_r == TOKEN_LEN_SAT) ? tl_r : tl_r + 16'd1;

  // one step of the sequencer: at most one result per cycle
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    end_pend_nxt = end_pend_r;
    ended_nxt    = ended_r;
    tl_nxt       = tl_r;
    ovf_nxt      = ovf_r;
    next_mode    = mode;
    emit_byte    = 1'b0;
    emit_close   = 1'b0;
    done         = 1'b0;
    clear_str    = 1'b0;
    shift        = 1'b0;
    push         = 1'b0;
    res          = '0;
    if ((mode != ST_IDLE) && space) begin
      count_nxt = c;
      ended_nxt = ended_e;
      unique case (mode)
        ST_SCAN: begin
          if (!pre0) begin
            // front byte can no longer start a match
            emit_byte = 1'b1;
            done      = !endp && pre1 && (c_m1 < len);
          end else if (c == len) begin
            // full match closes the token
            emit_close = 1'b1;
            done       = 1'b1;
            clear_str  = endp;
          end else if (endp) begin
            // string ends with a partial match pending: flush it
            if (c != '0) begin
              emit_byte = 1'b1;
              next_mode = ST_FLUSH;
            end else begin
              emit_close = 1'b1;
              done       = 1'b1;
              clear_str  = 1'b1;
            end
          end else begin
            // byte held as a possible delimiter start
            done = 1'b1;
          end
        end
        ST_FLUSH: begin
          if (c != '0) begin
            emit_byte = 1'b1;
          end else if (!ended_e) begin
            emit_close = 1'b1;
            done       = 1'b1;
            clear_str  = 1'b1;
          end else begin
            // string ended right on a delimiter, no trailing token
            done      = 1'b1;
            clear_str = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase

      if (emit_byte) begin
        shift           = 1'b1;
        count_nxt       = c_m1;
        tl_nxt          = tl_inc;
        ovf_nxt         = ovf_r || (tl_inc > max_tok_r);
        res.token_byte  = eff[0];
      end
      if (emit_close) begin
        count_nxt          = '0;
        ended_nxt          = 1'b1;
        tl_nxt             = '0;
        ovf_nxt            = 1'b0;
        res.close_token    = 1'b1;
        res.token_overflow = ovf_r;
      end
      if (clear_str) begin
        count_nxt = '0;
        ended_nxt = 1'b0;
        tl_nxt    = '0;
        ovf_nxt   = 1'b0;
      end
      res.last_of_run = done;
      push            = emit_byte || emit_close;
      state_nxt       = done ? ST_IDLE : next_mode;
      end_pend_nxt    = done ? 1'b0 : endp;
    end
  end

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_len_r <= DELIM_LENGTH_RESET;
      delim_lo_r  <= DELIM_LOW_RESET;
      delim_hi_r  <= DELIM_HIGH_RESET;
      max_tok_r   <= TOKEN_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DELIM_LENGTH: delim_len_r <= cfg_data[4:0];
        CFG_DELIM_LOW:    delim_lo_r  <= cfg_data;
        CFG_DELIM_HIGH:   delim_hi_r  <= cfg_data;
        CFG_MAX_TOKEN:    max_tok_r   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      end_pend_r <= 1'b0;
      ended_r    <= 1'b0;
      tl_r       <= '0;
      ovf_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      end_pend_r <= end_pend_nxt;
      ended_r    <= ended_nxt;
      tl_r       <= tl_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // results leave through a two-entry buffer that absorbs a stall until it is full
  sds_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = out_res.token_byte;
  assign out_tuser = {out_res.token_overflow, out_res.close_token};
  assign out_tlast = out_res.last_of_run;

  // a busy sequencer with buffer room always produces a result
  `SDS_ASSERT_IMP(a_busy_pushes, (state_r != ST_IDLE) && space, push, "busy step without result")
  // between items the window never fills the whole chain
  `SDS_ASSERT_IMP(a_idle_window, state_r == ST_IDLE, count_r < CW'(DELIM_MAX), "window overfull")
  // a token close restarts the length count
  `SDS_ASSERT_NXT(a_close_clears, push && res.close_token, (tl_r == '0) && !ovf_r, "close kept length")
  // a match that ended the string leaves an empty window
  `SDS_ASSERT_IMP(a_ended_empty, ended_r, count_r == '0, "ended on delimiter with bytes held")

endmodule

// File: src/sds_cell.sv
// one window cell: holds a byte, compares it against two delimiter positions
`timescale 1ns / 1ps
module sds_cell (
  input  logic              clk,
  input  sds_pkg::cell_ctl_t ctl,
  input  sds_pkg::byte_t    in_byte,
  input  sds_pkg::byte_t    next_eff,
  input  sds_pkg::byte_t    d_here,
  input  sds_pkg::byte_t    d_prev,
  output sds_pkg::byte_t    eff,
  output logic              eq0,
  output logic              eq1
);
  import sds_pkg::*;

  byte_t byte_r;
  byte_t byte_nxt;

  // incoming byte lands here when this is the next free slot
  assign eff = ctl.take_in ? in_byte : byte_r;
  assign eq0 = (eff == d_here);
  assign eq1 = (eff == d_prev);

  always_comb begin
    byte_nxt = ctl.shift ? next_eff : eff;
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

// File: src/sds_out_buf.sv
// two-entry result buffer between the splitter core and the output stream
`timescale 1ns / 1ps
module sds_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sds_pkg::result_t push_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output sds_pkg::result_t out_data
);
  import sds_pkg::*;

  result_t    ent_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign out_data  = ent_r[rd_ptr_r];
  assign space     = (count_r != 2'd2);
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
